@@ rtl/dhoat_pkg.sv @@
// shared types, constants and hash function for the double-hash table
package dhoat_pkg;

   localparam int BUCKETS    = 1024;
   localparam int ADDR_BITS  = $clog2(BUCKETS);
   localparam int CNT_BITS   = $clog2(BUCKETS + 1);
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;

   localparam logic [31:0] SEED_H1 = 32'h5cd902cb;
   localparam logic [31:0] SEED_H2 = 32'h80435418;

   // operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_GET   = 2'd1;
   localparam logic [1:0] OP_DEL   = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_NONE    = 2'd0;
   localparam logic [1:0] STAT_FOUND   = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_IGNORED = 2'd3;

   // bucket state codes
   localparam logic [1:0] BK_EMPTY    = 2'd0;
   localparam logic [1:0] BK_OCCUPIED = 2'd1;
   localparam logic [1:0] BK_DELETED  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       clear_step;
      logic       load;
      logic       read;
      logic       advance;
      logic       set_value;
      logic       set_tomb;
      logic       insert;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_from_mem;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_done;
      logic [1:0] bucket;
      logic       key_hit;
      logic       last_probe;
      logic       have_free;
      logic [1:0] op;
      logic       del_en;
   } stat_type;

   // xor fold of the seeded key into a bucket index
   function automatic logic [ADDR_BITS-1:0] fold_hash(input logic [KEY_BITS-1:0] key,
                                                       input logic [31:0] seed);
      logic [KEY_BITS-1:0]  x;
      logic [ADDR_BITS-1:0] acc;
      x   = key ^ KEY_BITS'({seed, ~seed});
      acc = '0;
      for (int i = 0; i < KEY_BITS; i += ADDR_BITS) begin
         acc ^= ADDR_BITS'(x >> i);
      end
      return acc;
   endfunction

endpackage

@@ rtl/dhoat_ctrl.sv @@
// controller state machine: clearing pass, probe loop and response handshake
module dhoat_ctrl import dhoat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_RESP} state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      is_add, trivial, hit;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign is_add    = (stat.op == OP_ADD);
   assign trivial   = (stat.op == OP_SPARE) || ((stat.op == OP_DEL) && !stat.del_en);
   assign hit       = (stat.bucket == BK_OCCUPIED) && stat.key_hit;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clr_done) begin
               state_in     = S_IDLE;
               req_ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            if (trivial) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = (stat.op == OP_DEL) ? STAT_IGNORED : STAT_NONE;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.read = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (hit) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_status   = STAT_FOUND;
               cmd.rsp_from_mem = 1'b1;
               cmd.set_value    = is_add;
               cmd.set_tomb     = (stat.op == OP_DEL);
               rsp_valid_in     = 1'b1;
               state_in         = S_RESP;
            end else if (stat.bucket == BK_EMPTY) begin
               cmd.insert     = is_add;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_NONE;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else if (stat.last_probe) begin
               // probe path exhausted
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
               if (is_add && (stat.have_free || stat.bucket == BK_DELETED)) begin
                  cmd.insert     = 1'b1;
                  cmd.rsp_status = STAT_NONE;
               end else if (is_add) begin
                  cmd.rsp_status = STAT_FULL;
               end else begin
                  cmd.rsp_status = STAT_NONE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/dhoat_dp.sv @@
// datapath: bucket, key and value memories, probe address, count and result word
module dhoat_dp import dhoat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [1:0]            req_opcode,
   input  logic [KEY_BITS-1:0]   req_lookup_key,
   input  logic [VALUE_BITS-1:0] req_entry_value,
   input  logic                  csr_valid,
   input  logic                  csr_deletion_enable,
   output logic [1:0]            rsp_status,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic [CNT_BITS-1:0]   rsp_element_count
);

   logic [1:0]            bucket_mem [BUCKETS];
   logic [KEY_BITS-1:0]   key_mem    [BUCKETS];
   logic [VALUE_BITS-1:0] value_mem  [BUCKETS];

   logic [ADDR_BITS-1:0]  clr_ff, bucket_ff, h2_ff, step_ff, free_ff, ins_addr;
   logic                  have_free_ff, del_en_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [1:0]            op_ff, bk_q, rsp_status_ff;
   logic [KEY_BITS-1:0]   key_ff, key_q;
   logic [VALUE_BITS-1:0] val_ff, val_q, rsp_value_ff;

   assign ins_addr = have_free_ff ? free_ff : bucket_ff;

   assign stat.clr_done   = (clr_ff == ADDR_BITS'(BUCKETS - 1));
   assign stat.bucket     = bk_q;
   assign stat.key_hit    = (key_q == key_ff);
   assign stat.last_probe = (step_ff == ADDR_BITS'(BUCKETS - 1));
   assign stat.have_free  = have_free_ff;
   assign stat.op         = op_ff;
   assign stat.del_en     = del_en_ff;

   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_element_count = count_ff;

   // control registers: clear counter, register, count
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         del_en_ff <= 1'b1;
         count_ff  <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + ADDR_BITS'(1);
         if (csr_valid) del_en_ff <= csr_deletion_enable;
         if (cmd.insert) count_ff <= count_ff + CNT_BITS'(1);
         else if (cmd.set_tomb) count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   // operation word and probe sequence
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_opcode;
         key_ff       <= req_lookup_key;
         val_ff       <= req_entry_value;
         bucket_ff    <= fold_hash(req_lookup_key, SEED_H1);
         h2_ff        <= fold_hash(req_lookup_key, SEED_H2) | ADDR_BITS'(1);
         step_ff      <= '0;
         have_free_ff <= 1'b0;
      end else if (cmd.advance) begin
         bucket_ff <= bucket_ff + h2_ff;
         step_ff   <= step_ff + ADDR_BITS'(1);
         if (bk_q == BK_DELETED && !have_free_ff) begin
            have_free_ff <= 1'b1;
            free_ff      <= bucket_ff;
         end
      end
   end

   // bucket state memory
   always_ff @(posedge clock) begin
      if (cmd.clear_step) bucket_mem[clr_ff] <= BK_EMPTY;
      else if (cmd.set_tomb) bucket_mem[bucket_ff] <= BK_DELETED;
      else if (cmd.insert) bucket_mem[ins_addr] <= BK_OCCUPIED;
      if (cmd.read) bk_q <= bucket_mem[bucket_ff];
   end

   // key memory
   always_ff @(posedge clock) begin
      if (cmd.insert) key_mem[ins_addr] <= key_ff;
      if (cmd.read) key_q <= key_mem[bucket_ff];
   end

   // value memory
   always_ff @(posedge clock) begin
      if (cmd.insert) value_mem[ins_addr] <= val_ff;
      else if (cmd.set_value) value_mem[bucket_ff] <= val_ff;
      if (cmd.read) val_q <= value_mem[bucket_ff];
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= cmd.rsp_from_mem ? val_q : '0;
      end
   end

endmodule

@@ rtl/double_hash_open_address_table.sv @@
// top level of the double-hash open-addressing key/value table
//
//   channel | direction | ports
//   req     | in        | req_opcode, req_lookup_key, req_entry_value
//   rsp     | out       | rsp_status, rsp_read_value, rsp_element_count
//   csr     | in        | csr_deletion_enable
//
// each probe of an accepted request word is a bucket memory read followed by a
// compare of the read bucket; an ignored delete or an unused opcode answers
// without reading the table, and the response word is held while rsp_ready is low.
// after reset a clearing pass empties the bucket states;
// req_ready stays low during it, csr writes are taken at any time.
// one operation is in flight at a time; req_ready returns once the response word is taken.
module double_hash_open_address_table import dhoat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [KEY_BITS-1:0]   req_lookup_key,
   input  logic [VALUE_BITS-1:0] req_entry_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic [CNT_BITS-1:0]   rsp_element_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_deletion_enable
);

   cmd_type  cmd;
   stat_type stat;

   // register port always ready
   assign csr_ready = 1'b1;

   // controller
   dhoat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   dhoat_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_lookup_key      (req_lookup_key),
      .req_entry_value     (req_entry_value),
      .csr_valid           (csr_valid),
      .csr_deletion_enable (csr_deletion_enable),
      .rsp_status          (rsp_status),
      .rsp_read_value      (rsp_read_value),
      .rsp_element_count   (rsp_element_count)
   );

endmodule
